FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers for the rtl files, used by range_cover_union_counter_unit
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// assertion on an explicit clock and active-low reset
`define RCU_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// assertion on the usual clk_i / rst_ni pair
`define RCU_ASSERT(lbl, prop, msg) \
  `RCU_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

FILE: rtl/rcu_pkg.sv
// ----------------------------------------------------------------------------
// rcu_pkg
// shared constants and the transaction type that walks along the cell chain
// ----------------------------------------------------------------------------
package rcu_pkg;

  localparam int unsigned POSITIONS_DEF   = 1024;
  localparam int unsigned COUNT_WIDTH_DEF = 16;
  localparam int unsigned RANGE_W         = 10;
  localparam int unsigned COUNT_OUT_W     = 11;
  localparam int unsigned COUNT_OUT_MAX   = 2047;
  // positions held by one cell of the chain
  localparam int unsigned CELL_LANES      = 16;

  typedef struct packed {
    logic               valid;
    logic [RANGE_W-1:0] low;
    logic [RANGE_W-1:0] high;
    logic               remove;
    logic               under;
  } item_t;

endpackage

FILE: rtl/rcu_lane.sv
// ----------------------------------------------------------------------------
// rcu_lane
// one cover counter for a single fixed position
// ----------------------------------------------------------------------------
module rcu_lane #(
  parameter int unsigned POS         = 0,
  parameter int unsigned IDX_W       = rcu_pkg::RANGE_W,
  parameter int unsigned COUNT_WIDTH = rcu_pkg::COUNT_WIDTH_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  rcu_pkg::item_t item_i,
  output logic          nonzero_o,
  output logic          under_o
);

  localparam logic [IDX_W-1:0]       POS_C   = IDX_W'(POS);
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

  logic [COUNT_WIDTH-1:0] cnt_q, cnt_d;
  logic                   hit;
  logic                   is_zero;

  assign hit = (IDX_W'(item_i.low) <= POS_C) && (POS_C <= IDX_W'(item_i.high));
  assign is_zero = (cnt_q == '0);

  always_comb begin
    cnt_d = cnt_q;
    if (en_i && hit) begin
      if (item_i.remove) begin
        if (!is_zero) begin
          cnt_d = cnt_q - COUNT_WIDTH'(1);
        end
      end else if (cnt_q != CNT_MAX) begin
        cnt_d = cnt_q + COUNT_WIDTH'(1);
      end
    end
  end

  // occupancy after this transaction, without waiting for the counter update
  assign nonzero_o = hit ? (item_i.remove ? (cnt_q > COUNT_WIDTH'(1)) : 1'b1) : !is_zero;
  assign under_o   = hit && item_i.remove && is_zero;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

endmodule

FILE: rtl/rcu_cell.sv
// ----------------------------------------------------------------------------
// rcu_cell
// one link of the chain: a group of position counters, their local
// occupancy count and the stage register towards the next cell
// ----------------------------------------------------------------------------
module rcu_cell #(
  parameter int unsigned BASE        = 0,
  parameter int unsigned LANES       = rcu_pkg::CELL_LANES,
  parameter int unsigned IDX_W       = rcu_pkg::RANGE_W,
  parameter int unsigned COUNT_WIDTH = rcu_pkg::COUNT_WIDTH_DEF,
  parameter int unsigned SUM_W       = rcu_pkg::COUNT_OUT_W
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             advance_i,
  input  rcu_pkg::item_t   item_i,
  input  logic [SUM_W-1:0] sum_i,
  output rcu_pkg::item_t   item_o,
  output logic [SUM_W-1:0] sum_o
);

  localparam int unsigned LW = $clog2(LANES + 1);

  logic [LANES-1:0] nonzero;
  logic [LANES-1:0] under;
  logic [LW-1:0]    local_cnt;
  logic             en;
  rcu_pkg::item_t   item_d, item_q;
  logic [SUM_W-1:0] sum_d, sum_q;

  assign en = advance_i && item_i.valid;

  for (genvar j = 0; j < LANES; j++) begin : g_lane
    rcu_lane #(
      .POS         (BASE + j),
      .IDX_W       (IDX_W),
      .COUNT_WIDTH (COUNT_WIDTH)
    ) u_lane (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .en_i      (en),
      .item_i    (item_i),
      .nonzero_o (nonzero[j]),
      .under_o   (under[j])
    );
  end

  always_comb begin
    local_cnt = '0;
    for (int unsigned i = 0; i < LANES; i++) begin
      local_cnt = local_cnt + LW'(nonzero[i]);
    end
  end

  always_comb begin
    item_d       = item_i;
    item_d.under = item_i.under | (|under);
    sum_d        = sum_i + SUM_W'(local_cnt);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_q <= '0;
    end else if (advance_i) begin
      item_q <= item_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      sum_q <= sum_d;
    end
  end

  assign item_o = item_q;
  assign sum_o  = sum_q;

endmodule

FILE: rtl/range_cover_union_counter_unit.sv
// ----------------------------------------------------------------------------
// range_cover_union_counter_unit
// cover counters over a row of positions, reporting the covered length
// ----------------------------------------------------------------------------
// Every transaction adds or removes one cover over an inclusive range and
// returns the number of positions left with a nonzero counter, plus an
// underflow flag for a removal that met an empty position. The positions are
// split over a chain of cells of 16 positions each, the last possibly fewer
// (64 cells for 1024 positions). A transaction walks the chain one cell per
// cycle while the chain advances, updating that cell's counters and adding
// its occupancy to a running total, so a new transaction can be taken every
// cycle unless the chain is stalled. The last stage of the chain is the
// output register; while it is stalled the whole chain holds. Counters are
// cleared by reset, with no start-up sweep.
`include "assert_macros.svh"

module range_cover_union_counter_unit #(
  parameter int unsigned POSITIONS   = rcu_pkg::POSITIONS_DEF,
  parameter int unsigned COUNT_WIDTH = rcu_pkg::COUNT_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [rcu_pkg::RANGE_W-1:0]     range_low_i,
  input  logic [rcu_pkg::RANGE_W-1:0]     range_high_i,
  input  logic                            remove_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [rcu_pkg::COUNT_OUT_W-1:0] covered_count_o,
  output logic                            underflow_o
);

  localparam int unsigned NCELLS = (POSITIONS + rcu_pkg::CELL_LANES - 1) / rcu_pkg::CELL_LANES;
  localparam int unsigned IDX_W  = ($clog2(POSITIONS) > rcu_pkg::RANGE_W) ?
                                   $clog2(POSITIONS) : rcu_pkg::RANGE_W;
  localparam int unsigned SUM_W  = $clog2(POSITIONS + 1);

  rcu_pkg::item_t   item_s [NCELLS+1];
  logic [SUM_W-1:0] sum_s  [NCELLS+1];
  logic [NCELLS-1:0] stage_valid;
  logic             advance;

  // whole chain moves unless the output stage holds a result that is stalled
  assign advance    = !item_s[NCELLS].valid || !out_stall_i;
  assign in_stall_o = !advance;

  always_comb begin
    item_s[0].valid  = in_valid_i;
    item_s[0].low    = range_low_i;
    item_s[0].high   = range_high_i;
    item_s[0].remove = remove_i;
    item_s[0].under  = 1'b0;
    sum_s[0]         = '0;
  end

  for (genvar k = 0; k < NCELLS; k++) begin : g_cell
    localparam int unsigned BASE  = k * rcu_pkg::CELL_LANES;
    localparam int unsigned LANES = (k < NCELLS - 1) ? rcu_pkg::CELL_LANES : POSITIONS - BASE;

    rcu_cell #(
      .BASE        (BASE),
      .LANES       (LANES),
      .IDX_W       (IDX_W),
      .COUNT_WIDTH (COUNT_WIDTH),
      .SUM_W       (SUM_W)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .advance_i (advance),
      .item_i    (item_s[k]),
      .sum_i     (sum_s[k]),
      .item_o    (item_s[k+1]),
      .sum_o     (sum_s[k+1])
    );

    assign stage_valid[k] = item_s[k+1].valid;
  end

  assign out_valid_o = item_s[NCELLS].valid;
  assign underflow_o = item_s[NCELLS].under;

  if (SUM_W > rcu_pkg::COUNT_OUT_W) begin : g_sat
    assign covered_count_o = (sum_s[NCELLS] > SUM_W'(rcu_pkg::COUNT_OUT_MAX)) ?
                             rcu_pkg::COUNT_OUT_W'(rcu_pkg::COUNT_OUT_MAX) :
                             sum_s[NCELLS][rcu_pkg::COUNT_OUT_W-1:0];
  end else begin : g_nosat
    assign covered_count_o = rcu_pkg::COUNT_OUT_W'(sum_s[NCELLS]);
  end

  // a stalled result freezes every stage of the chain
  `RCU_ASSERT(a_chain_holds, out_valid_o && out_stall_i |=> $stable(stage_valid), "chain moved")
  // underflow can only come from a removal
  `RCU_ASSERT(a_under_remove, out_valid_o && underflow_o |-> item_s[NCELLS].remove, "add flagged")
  // covered length never exceeds the number of positions
  `RCU_ASSERT(a_count_bound, out_valid_o |-> (32'(covered_count_o) <= POSITIONS), "count too big")

endmodule

FILE: tb/range_cover_union_counter_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_cover_union_counter_unit_tb
// self-checking bench for the range cover union counter
// ----------------------------------------------------------------------------
// Drives cover additions and removals over position ranges through the
// valid/stall input channel and checks every covered length and underflow
// flag against a per-position counter predictor. A short directed run hits
// full, empty, single-position and underflowing ranges. Random traffic
// follows, mixing additions, matched removals, random removals and swapped
// ranges. Random idle gaps and output stalls are on for most of the run.

class union_length_tracker;
  typedef struct {
    logic [rcu_pkg::COUNT_OUT_W-1:0] covered;
    logic                            under;
  } cover_result_t;

  bit [rcu_pkg::COUNT_WIDTH_DEF-1:0] cover_cnt [rcu_pkg::POSITIONS_DEF];
  int unsigned                       covered_total;
  cover_result_t                     expected_lengths[$];
  int                                errors;

  task report(input string msg);
    if (errors < 100) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
    errors++;
  endtask

  // one accepted transaction: update counters, queue the expected result
  function void apply_cover(input logic [rcu_pkg::RANGE_W-1:0] lo,
                            input logic [rcu_pkg::RANGE_W-1:0] hi,
                            input logic rem);
    int unsigned   top;
    bit            under;
    cover_result_t res;
    top   = hi;
    under = 1'b0;
    if (top > rcu_pkg::POSITIONS_DEF - 1) begin
      top = rcu_pkg::POSITIONS_DEF - 1;
    end
    for (int unsigned p = lo; p <= top; p++) begin
      if (rem) begin
        if (cover_cnt[p] == '0) begin
          under = 1'b1;
        end else begin
          cover_cnt[p]--;
          if (cover_cnt[p] == '0) covered_total--;
        end
      end else if (cover_cnt[p] != '1) begin
        if (cover_cnt[p] == '0) covered_total++;
        cover_cnt[p]++;
      end
    end
    res.covered = rcu_pkg::COUNT_OUT_W'((covered_total > rcu_pkg::COUNT_OUT_MAX) ?
                                        rcu_pkg::COUNT_OUT_MAX : covered_total);
    res.under   = under;
    expected_lengths = {expected_lengths, res};
  endfunction

  task check_length(input logic [rcu_pkg::COUNT_OUT_W-1:0] covered,
                    input logic under);
    cover_result_t exp_res;
    if (expected_lengths.size() == 0) begin
      report($sformatf("unexpected result covered_count=%0d underflow=%0b",
                       covered, under));
    end else begin
      exp_res = expected_lengths.pop_front();
      if (covered !== exp_res.covered) begin
        report($sformatf("covered_count got %0d, want %0d", covered, exp_res.covered));
      end
      if (under !== exp_res.under) begin
        report($sformatf("underflow got %0b, want %0b", under, exp_res.under));
      end
    end
  endtask
endclass

module range_cover_union_counter_unit_tb;

  typedef struct {
    logic [rcu_pkg::RANGE_W-1:0] lo;
    logic [rcu_pkg::RANGE_W-1:0] hi;
  } span_t;

  localparam int unsigned LAST_POS = rcu_pkg::POSITIONS_DEF - 1;

  logic                            clk_i           = 1'b0;
  logic                            rst_ni          = 1'b0;
  logic                            in_valid_i      = 1'b0;
  logic                            in_stall_o;
  logic [rcu_pkg::RANGE_W-1:0]     range_low_i     = '0;
  logic [rcu_pkg::RANGE_W-1:0]     range_high_i    = '0;
  logic                            remove_i        = 1'b0;
  logic                            out_valid_o;
  logic                            out_stall_i     = 1'b0;
  logic [rcu_pkg::COUNT_OUT_W-1:0] covered_count_o;
  logic                            underflow_o;

  union_length_tracker tracker;
  bit                  idle_en = 1'b0;
  span_t               live_spans[$];

  range_cover_union_counter_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .range_low_i     (range_low_i),
    .range_high_i    (range_high_i),
    .remove_i        (remove_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .covered_count_o (covered_count_o),
    .underflow_o     (underflow_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // mostly none, sometimes short, now and then long
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return $urandom_range(20, 60);
    if (r < 7) return $urandom_range(1, 4);
    return 0;
  endfunction

  task automatic send_cover(input logic [rcu_pkg::RANGE_W-1:0] lo,
                            input logic [rcu_pkg::RANGE_W-1:0] hi,
                            input logic rem);
    int unsigned gap;
    gap = idle_en ? idle_len() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    range_low_i  <= lo;
    range_high_i <= hi;
    remove_i     <= rem;
    do @(posedge clk_i); while (in_stall_o);
    tracker.apply_cover(lo, hi, rem);
  endtask

  task automatic pick_span(output logic [rcu_pkg::RANGE_W-1:0] lo,
                           output logic [rcu_pkg::RANGE_W-1:0] hi);
    int unsigned a;
    int unsigned b;
    int unsigned t;
    case ($urandom_range(0, 4))
      0: begin
        a = $urandom_range(0, LAST_POS);
        b = $urandom_range(0, LAST_POS);
      end
      1: begin
        a = $urandom_range(0, LAST_POS);
        b = a + $urandom_range(0, 15);
      end
      2: begin
        a = 0;
        b = $urandom_range(0, LAST_POS);
      end
      3: begin
        a = $urandom_range(0, LAST_POS);
        b = LAST_POS;
      end
      default: begin
        a = $urandom_range(0, LAST_POS);
        b = a;
      end
    endcase
    if (b > LAST_POS) b = LAST_POS;
    if (a > b) begin
      t = a;
      a = b;
      b = t;
    end
    lo = rcu_pkg::RANGE_W'(a);
    hi = rcu_pkg::RANGE_W'(b);
  endtask

  // output side back-pressure
  initial begin
    forever begin
      @(posedge clk_i);
      if (idle_en && $urandom_range(0, 3) == 0) begin
        out_stall_i <= 1'b1;
        repeat (idle_len() + 1) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      tracker.check_length(covered_count_o, underflow_o);
    end
  end

  initial begin
    span_t                       sp;
    logic [rcu_pkg::RANGE_W-1:0] lo;
    logic [rcu_pkg::RANGE_W-1:0] hi;
    int unsigned                 k;
    int unsigned                 r;

    tracker = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    idle_en = 1'b1;
    send_cover(10'd0, 10'd1023, 1'b0);
    send_cover(10'd0, 10'd1023, 1'b1);
    send_cover(10'd5, 10'd5, 1'b1);         // removal at zero
    send_cover(10'd1023, 10'd0, 1'b0);      // empty range
    send_cover(10'd600, 10'd599, 1'b1);     // empty removal, no flag
    send_cover(10'd0, 10'd0, 1'b0);
    send_cover(10'd1023, 10'd1023, 1'b0);
    send_cover(10'd512, 10'd767, 1'b0);
    send_cover(10'd700, 10'd900, 1'b0);
    send_cover(10'd700, 10'd900, 1'b1);
    send_cover(10'd341, 10'd682, 1'b0);
    send_cover(10'd682, 10'd341, 1'b1);
    send_cover(10'd0, 10'd1023, 1'b1);      // partial underflow, rest decremented
    send_cover(10'd682, 10'd682, 1'b0);
    send_cover(10'd341, 10'd341, 1'b1);
    send_cover(10'd0, 10'd1023, 1'b0);
    send_cover(10'd1, 10'd1022, 1'b0);
    send_cover(10'd0, 10'd1023, 1'b1);
    send_cover(10'd1, 10'd1022, 1'b1);

    for (k = 0; k < 400; k++) begin
      if (k % 50 == 0) idle_en = ($urandom_range(0, 3) != 0);
      r = $urandom_range(0, 99);
      if ((r < 45 || live_spans.size() == 0) && live_spans.size() < 40) begin
        pick_span(lo, hi);
        sp.lo = lo;
        sp.hi = hi;
        live_spans = {live_spans, sp};
        send_cover(lo, hi, 1'b0);
      end else if (r < 85 && live_spans.size() != 0) begin
        // matched removal of an earlier addition
        r  = $urandom_range(0, live_spans.size() - 1);
        sp = live_spans[r];
        live_spans.delete(r);
        send_cover(sp.lo, sp.hi, 1'b1);
      end else if (r < 93) begin
        send_cover(rcu_pkg::RANGE_W'($urandom_range(0, LAST_POS)),
                   rcu_pkg::RANGE_W'($urandom_range(0, LAST_POS)), 1'b1);
      end else begin
        pick_span(lo, hi);
        if (lo != hi) begin
          send_cover(hi, lo, 1'($urandom_range(0, 1)));
        end else begin
          send_cover(rcu_pkg::RANGE_W'($urandom), rcu_pkg::RANGE_W'($urandom),
                     1'($urandom_range(0, 1)));
        end
      end
    end
    in_valid_i <= 1'b0;

    while (tracker.expected_lengths.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (tracker.errors == 0 && tracker.expected_lengths.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
